// ----- rtl/core/asc128_pkg.sv -----
// ---------------------------------------------------------------------------
// Ascon-128 AEAD encryption package
// Beat types, operation codes and the shared permutation round.
// ---------------------------------------------------------------------------
package asc128_pkg;

    localparam logic [1:0]  OP_START = 2'd0;
    localparam logic [1:0]  OP_AD    = 2'd1;
    localparam logic [1:0]  OP_PT    = 2'd2;

    localparam logic        KIND_CT  = 1'b0;
    localparam logic        KIND_TAG = 1'b1;

    localparam logic        REG_KEY_HIGH = 1'b0;
    localparam logic        REG_KEY_LOW  = 1'b1;

    localparam logic [63:0] ASCON_IV = 64'h8040_0c06_0000_0000;
    localparam logic [63:0] PAD_TOP  = 64'h8000_0000_0000_0000;
    localparam logic [3:0]  LAST_RND = 4'd11;
    localparam logic [3:0]  FULL_NB  = 4'd8;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] nonce_high;
        logic [63:0] nonce_low;
        logic [63:0] data_block;
        logic [3:0]  valid_bytes;
        logic        last_block;
    } t_in_beat;

    typedef struct packed {
        logic        kind;
        logic [63:0] out_high;
        logic [63:0] out_low;
        logic [3:0]  out_bytes;
        logic        final_item;
    } t_out_beat;

    typedef logic [4:0][63:0] t_state;

    function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned n);
        return (v >> n) | (v << (64 - n));
    endfunction

    // leading n bytes kept, n in 0..8
    function automatic logic [63:0] lead_mask(input logic [3:0] n);
        logic [2:0] sh;
        sh = 3'(FULL_NB - n);
        if (n == 4'd0) begin
            return '0;
        end else if (n >= FULL_NB) begin
            return '1;
        end
        return '1 << {sh, 3'b000};
    endfunction

    // partial final block with 0x80 padding, n in 0..7
    function automatic logic [63:0] pad_block(input logic [63:0] d, input logic [3:0] n);
        return (d & lead_mask(n)) ^ (PAD_TOP >> {n[2:0], 3'b000});
    endfunction

    function automatic logic [3:0] sat_bytes(input logic [3:0] n);
        return (n > FULL_NB) ? FULL_NB : n;
    endfunction

    // round constant: 0xf0, 0xe1, ... 0x4b
    function automatic t_state asc_round(input t_state s, input logic [3:0] idx);
        logic [63:0] a0, a1, a2, a3, a4, b0, b1, b2, b3, b4;
        t_state      r;
        a2 = s[2] ^ {56'd0, ~idx, idx};
        a0 = s[0] ^ s[4];
        a4 = s[4] ^ s[3];
        a2 = a2 ^ s[1];
        a1 = s[1];
        a3 = s[3];
        b0 = a0 ^ (~a1 & a2);
        b1 = a1 ^ (~a2 & a3);
        b2 = a2 ^ (~a3 & a4);
        b3 = a3 ^ (~a4 & a0);
        b4 = a4 ^ (~a0 & a1);
        b1 = b1 ^ b0;
        b0 = b0 ^ b4;
        b3 = b3 ^ b2;
        b2 = ~b2;
        r[0] = b0 ^ rotr(b0, 19) ^ rotr(b0, 28);
        r[1] = b1 ^ rotr(b1, 61) ^ rotr(b1, 39);
        r[2] = b2 ^ rotr(b2, 1)  ^ rotr(b2, 6);
        r[3] = b3 ^ rotr(b3, 10) ^ rotr(b3, 17);
        r[4] = b4 ^ rotr(b4, 7)  ^ rotr(b4, 41);
        return r;
    endfunction

endpackage

// ----- rtl/core/ascon128_aead_encrypt_unit.sv -----
// A ciphertext beat is registered in S_PT once its plaintext beat is taken (after S_ROUND and
// S_DSEP if associated data is still open); the tag is registered in S_TAG after S_ROUND for a
// partial final ciphertext beat, after S_ROUND, S_FIN and S_ROUND for a full one. Start runs 12
// rounds, a data block 6, a full final associated-data block 6 and 6 more, all on the single
// shared round unit (one round per cycle); the input stalls while a block is in work.
// Reset: synchronous active-low; clears sequencer, phase, sponge, output valid and key.
// ---------------------------------------------------------------------------
// Ascon-128 AEAD encryption unit
// Iterative sponge with one shared permutation round under a small sequencer.
// ---------------------------------------------------------------------------
module ascon128_aead_encrypt_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  asc128_pkg::t_in_beat  i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output asc128_pkg::t_out_beat o_data,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [63:0]           i_cfg_data
);
    import asc128_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ROUND, S_INIT, S_ADDONE, S_ADLAST, S_DSEP, S_PT, S_FIN, S_TAG
    } t_seq;

    typedef enum logic [1:0] {
        PH_IDLE, PH_START, PH_AD, PH_MSG
    } t_phase;

    t_seq        r_state, r_ret;
    t_phase      r_phase;
    logic [3:0]  r_rnd;
    t_state      r_s;
    t_in_beat    r_item;
    logic [63:0] r_key_high, r_key_low;
    logic        r_o_valid;
    t_out_beat   r_out;

    logic        w_acc, w_out_free, w_emit;
    logic [3:0]  w_in_nb, w_r_nb;
    logic        w_r_part;
    logic [63:0] w_pt_s0;

    assign w_acc      = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_emit     = (r_state == S_PT || r_state == S_TAG) && w_out_free;
    assign w_in_nb    = sat_bytes(i_data.valid_bytes);
    assign w_r_nb     = sat_bytes(r_item.valid_bytes);
    assign w_r_part   = r_item.last_block && (w_r_nb != FULL_NB);
    assign w_pt_s0    = r_s[0] ^ (w_r_part ? pad_block(r_item.data_block, w_r_nb)
                                           : r_item.data_block);

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_o_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_phase    <= PH_IDLE;
            r_rnd      <= '0;
            r_s        <= '0;
            r_o_valid  <= 1'b0;
            r_key_high <= '0;
            r_key_low  <= '0;
        end else begin
            if (r_o_valid && !i_stall && !w_emit) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_KEY_HIGH: r_key_high <= i_cfg_data;
                    REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    default:      r_key_low  <= r_key_low;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_item <= i_data;
                        unique case (i_data.op)
                            OP_START: begin
                                r_s     <= {i_data.nonce_low, i_data.nonce_high, r_key_low,
                                            r_key_high, ASCON_IV};
                                r_rnd   <= '0;
                                r_ret   <= S_INIT;
                                r_state <= S_ROUND;
                            end
                            OP_AD: begin
                                if (r_phase == PH_START || r_phase == PH_AD) begin
                                    r_rnd <= 4'd6;
                                    if (!i_data.last_block) begin
                                        r_s[0]  <= r_s[0] ^ i_data.data_block;
                                        r_ret   <= S_ADDONE;
                                        r_state <= S_ROUND;
                                    end else if (r_phase == PH_START && w_in_nb == 4'd0) begin
                                        r_s[4]  <= r_s[4] ^ 64'd1;
                                        r_phase <= PH_MSG;
                                    end else if (w_in_nb == FULL_NB) begin
                                        r_s[0]  <= r_s[0] ^ i_data.data_block;
                                        r_ret   <= S_ADLAST;
                                        r_state <= S_ROUND;
                                    end else begin
                                        r_s[0]  <= r_s[0] ^ pad_block(i_data.data_block,
                                                                      w_in_nb);
                                        r_ret   <= S_DSEP;
                                        r_state <= S_ROUND;
                                    end
                                end
                            end
                            OP_PT: begin
                                unique case (r_phase)
                                    PH_MSG:   r_state <= S_PT;
                                    PH_START: begin
                                        r_s[4]  <= r_s[4] ^ 64'd1;
                                        r_phase <= PH_MSG;
                                        r_state <= S_PT;
                                    end
                                    PH_AD: begin
                                        r_s[0]  <= r_s[0] ^ PAD_TOP;
                                        r_rnd   <= 4'd6;
                                        r_ret   <= S_DSEP;
                                        r_state <= S_ROUND;
                                    end
                                    default: r_state <= S_IDLE;
                                endcase
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ROUND: begin
                    r_s <= asc_round(r_s, r_rnd);
                    if (r_rnd == LAST_RND) begin
                        r_state <= r_ret;
                    end else begin
                        r_rnd <= r_rnd + 4'd1;
                    end
                end
                S_INIT: begin
                    r_s[3]  <= r_s[3] ^ r_key_high;
                    r_s[4]  <= r_s[4] ^ r_key_low;
                    r_phase <= PH_START;
                    r_state <= S_IDLE;
                end
                S_ADDONE: begin
                    r_phase <= PH_AD;
                    r_state <= S_IDLE;
                end
                S_ADLAST: begin
                    r_s[0]  <= r_s[0] ^ PAD_TOP;
                    r_rnd   <= 4'd6;
                    r_ret   <= S_DSEP;
                    r_state <= S_ROUND;
                end
                S_DSEP: begin
                    r_s[4]  <= r_s[4] ^ 64'd1;
                    r_phase <= PH_MSG;
                    r_state <= (r_item.op == OP_PT) ? S_PT : S_IDLE;
                end
                S_PT: begin
                    if (w_out_free) begin
                        r_o_valid          <= 1'b1;
                        r_out.kind         <= KIND_CT;
                        r_out.out_high     <= '0;
                        r_out.final_item   <= 1'b0;
                        r_s[0]             <= w_pt_s0;
                        if (w_r_part) begin
                            r_out.out_low   <= w_pt_s0 & lead_mask(w_r_nb);
                            r_out.out_bytes <= w_r_nb;
                            r_s[1]          <= r_s[1] ^ r_key_high;
                            r_s[2]          <= r_s[2] ^ r_key_low;
                            r_rnd           <= '0;
                            r_ret           <= S_TAG;
                        end else begin
                            r_out.out_low   <= w_pt_s0;
                            r_out.out_bytes <= FULL_NB;
                            r_rnd           <= 4'd6;
                            r_ret           <= r_item.last_block ? S_FIN : S_IDLE;
                        end
                        r_state <= S_ROUND;
                    end
                end
                S_FIN: begin
                    r_s[0]  <= r_s[0] ^ PAD_TOP;
                    r_s[1]  <= r_s[1] ^ r_key_high;
                    r_s[2]  <= r_s[2] ^ r_key_low;
                    r_rnd   <= '0;
                    r_ret   <= S_TAG;
                    r_state <= S_ROUND;
                end
                S_TAG: begin
                    if (w_out_free) begin
                        r_o_valid        <= 1'b1;
                        r_out.kind       <= KIND_TAG;
                        r_out.out_high   <= r_s[3] ^ r_key_high;
                        r_out.out_low    <= r_s[4] ^ r_key_low;
                        r_out.out_bytes  <= '0;
                        r_out.final_item <= 1'b1;
                        r_phase          <= PH_IDLE;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_tag_ends_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAG && w_out_free)
            |=> (r_phase == PH_IDLE && o_valid && o_data.final_item))
        else $error("tag beat did not close the message");

    a_kind_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.kind == o_data.final_item))
        else $error("kind and final flag disagree");

    a_ct_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.kind == KIND_CT)
            |-> (o_data.out_high == '0 && o_data.out_bytes <= FULL_NB))
        else $error("malformed ciphertext beat");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_rnd <= LAST_RND))
        else $error("round counter out of range");

    a_pt_needs_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PT) |-> (r_phase == PH_MSG))
        else $error("plaintext absorbed outside message phase");

endmodule

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// Ascon-128 AEAD encryption unit testbench
// Drives start, associated-data and plaintext beats with random gaps, stalls
// the result side at random, predicts every ciphertext and tag beat with an
// independent sponge model and compares them field by field in order. Keys
// are rewritten between phases while the unit is idle.
// ---------------------------------------------------------------------------
module testbench;
    import asc128_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_BEATS    = 250;
    localparam int MAX_PRINTS     = 50;

    typedef enum logic [1:0] {SP_IDLE, SP_OPEN, SP_AD, SP_MSG} t_sponge_phase;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic        o_stall;
    t_in_beat    i_data     = '0;
    logic        o_valid;
    logic        i_stall    = 1'b0;
    t_out_beat   o_data;
    logic        i_cfg_we   = 1'b0;
    logic        i_cfg_idx  = 1'b0;
    logic [63:0] i_cfg_data = '0;

    ascon128_aead_encrypt_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_in_beat      pending_beats[$];
    t_out_beat     expected_beats[$];
    t_state        sponge = '0;
    t_sponge_phase sp_phase = SP_IDLE;
    logic [63:0]   key_hi = '0;
    logic [63:0]   key_lo = '0;
    int            errors = 0;
    int            beats_queued = 0;
    int            tx_gap = 0;
    int            tx_calm = 0;
    int            rx_hold = 0;
    int            rx_calm = 0;
    int            quiet = 0;
    bit            tx_busy;

    function automatic logic [63:0] ror64(input logic [63:0] v, input int n);
        logic [127:0] d;
        d = {v, v} >> n;
        return d[63:0];
    endfunction

    function automatic logic [63:0] keep_bytes(input logic [3:0] n);
        logic [63:0] m;
        int          i;
        m = '0;
        for (i = 0; i < 8; i++)
            if (i < n) m[63 - 8 * i -: 8] = 8'hff;
        return m;
    endfunction

    function automatic void permute(input int rounds);
        logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
        int          r;
        for (r = 12 - rounds; r < 12; r++) begin
            x0 = sponge[0] ^ sponge[4];
            x1 = sponge[1];
            x2 = sponge[2] ^ 64'((15 - r) * 16 + r) ^ sponge[1];
            x3 = sponge[3];
            x4 = sponge[4] ^ sponge[3];
            t0 = x0 ^ (~x1 & x2);
            t1 = x1 ^ (~x2 & x3);
            t2 = x2 ^ (~x3 & x4);
            t3 = x3 ^ (~x4 & x0);
            t4 = x4 ^ (~x0 & x1);
            t1 = t1 ^ t0;
            t0 = t0 ^ t4;
            t3 = t3 ^ t2;
            t2 = ~t2;
            sponge[0] = t0 ^ ror64(t0, 19) ^ ror64(t0, 28);
            sponge[1] = t1 ^ ror64(t1, 61) ^ ror64(t1, 39);
            sponge[2] = t2 ^ ror64(t2, 1)  ^ ror64(t2, 6);
            sponge[3] = t3 ^ ror64(t3, 10) ^ ror64(t3, 17);
            sponge[4] = t4 ^ ror64(t4, 7)  ^ ror64(t4, 41);
        end
    endfunction

    function automatic void queue_result(input logic kind, input logic [63:0] hi,
                                         input logic [63:0] lo, input logic [3:0] nb,
                                         input logic fin);
        expected_beats.push_back('{kind, hi, lo, nb, fin});
    endfunction

    // sponge update for one accepted input beat
    function automatic void encrypt_step(input t_in_beat b);
        logic [3:0] nb;
        nb = (b.valid_bytes > FULL_NB) ? FULL_NB : b.valid_bytes;
        case (b.op)
            OP_START: begin
                sponge[0] = ASCON_IV;
                sponge[1] = key_hi;
                sponge[2] = key_lo;
                sponge[3] = b.nonce_high;
                sponge[4] = b.nonce_low;
                permute(12);
                sponge[3] ^= key_hi;
                sponge[4] ^= key_lo;
                sp_phase = SP_OPEN;
            end
            OP_AD: begin
                if (sp_phase == SP_OPEN || sp_phase == SP_AD) begin
                    if (!b.last_block) begin
                        sponge[0] ^= b.data_block;
                        permute(6);
                        sp_phase = SP_AD;
                    end else begin
                        // empty associated data: domain separation only
                        if (!(sp_phase == SP_OPEN && nb == 4'd0)) begin
                            if (nb == FULL_NB) begin
                                sponge[0] ^= b.data_block;
                                permute(6);
                                sponge[0] ^= PAD_TOP;
                            end else begin
                                sponge[0] ^= (b.data_block & keep_bytes(nb))
                                             ^ (PAD_TOP >> (8 * nb));
                            end
                            permute(6);
                        end
                        sponge[4][0] = ~sponge[4][0];
                        sp_phase = SP_MSG;
                    end
                end
            end
            OP_PT: begin
                if (sp_phase != SP_IDLE) begin
                    if (sp_phase == SP_AD) begin
                        sponge[0] ^= PAD_TOP;
                        permute(6);
                    end
                    if (sp_phase != SP_MSG) begin
                        sponge[4][0] = ~sponge[4][0];
                        sp_phase = SP_MSG;
                    end
                    if (!b.last_block) begin
                        sponge[0] ^= b.data_block;
                        queue_result(KIND_CT, '0, sponge[0], FULL_NB, 1'b0);
                        permute(6);
                    end else begin
                        if (nb == FULL_NB) begin
                            sponge[0] ^= b.data_block;
                            queue_result(KIND_CT, '0, sponge[0], FULL_NB, 1'b0);
                            permute(6);
                            sponge[0] ^= PAD_TOP;
                        end else begin
                            sponge[0] ^= (b.data_block & keep_bytes(nb))
                                         ^ (PAD_TOP >> (8 * nb));
                            queue_result(KIND_CT, '0, sponge[0] & keep_bytes(nb), nb, 1'b0);
                        end
                        sponge[1] ^= key_hi;
                        sponge[2] ^= key_lo;
                        permute(12);
                        sponge[3] ^= key_hi;
                        sponge[4] ^= key_lo;
                        queue_result(KIND_TAG, sponge[3], sponge[4], 4'd0, 1'b1);
                        sp_phase = SP_IDLE;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int gap_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < MAX_PRINTS)
            $display("ERROR %s: got %h, want %h", what, got, want);
        errors++;
    endtask

    // input side: beat driver and prediction on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            tx_busy = i_valid;
            if (i_valid && !o_stall) begin
                encrypt_step(i_data);
                tx_busy = 1'b0;
            end
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_beats.size() > 0) begin
                    i_data <= pending_beats.pop_front();
                    tx_busy = 1'b1;
                    tx_gap = gap_len(tx_calm);
                end
            end
            i_valid <= tx_busy;
        end
    end

    // result side: random stall and in-order compare
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("result beat with none expected", o_data.out_low, '0);
            end else begin
                want = expected_beats.pop_front();
                if (o_data.kind !== want.kind)
                    report_mismatch("kind", 64'(o_data.kind), 64'(want.kind));
                if (o_data.out_high !== want.out_high)
                    report_mismatch("out_high", o_data.out_high, want.out_high);
                if (o_data.out_low !== want.out_low)
                    report_mismatch("out_low", o_data.out_low, want.out_low);
                if (o_data.out_bytes !== want.out_bytes)
                    report_mismatch("out_bytes", 64'(o_data.out_bytes), 64'(want.out_bytes));
                if (o_data.final_item !== want.final_item)
                    report_mismatch("final_item", 64'(o_data.final_item),
                                    64'(want.final_item));
            end
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) rx_hold = gap_len(rx_calm);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("ascon128_aead_encrypt_unit: mismatch");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic logic [63:0] rnd64();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [3:0] rnd_nb();
        if ($urandom_range(0, 99) < 85) return 4'($urandom_range(0, 8));
        return 4'($urandom_range(9, 15));
    endfunction

    task automatic add_beat(input logic [1:0] op, input logic [63:0] nh,
                            input logic [63:0] nl, input logic [63:0] data,
                            input logic [3:0] nb, input logic last);
        pending_beats.push_back('{op, nh, nl, data, nb, last});
        beats_queued++;
    endtask

    task automatic add_message();
        int shape, n_ad, n_pt, k;
        shape = $urandom_range(0, 99);
        add_beat(OP_START, rnd64(), rnd64(), rnd64(), rnd_nb(), 1'($urandom));
        n_ad = $urandom_range(0, 3);
        for (k = 0; k < n_ad; k++)
            add_beat(OP_AD, rnd64(), rnd64(), rnd64(), rnd_nb(), 1'b0);
        if (shape < 5) return;
        // otherwise the associated data is left unterminated
        if (shape >= 15) add_beat(OP_AD, rnd64(), rnd64(), rnd64(), rnd_nb(), 1'b1);
        if (shape >= 92) add_beat(OP_AD, rnd64(), rnd64(), rnd64(), rnd_nb(), 1'($urandom));
        n_pt = $urandom_range(0, 4);
        for (k = 0; k < n_pt; k++)
            add_beat(OP_PT, rnd64(), rnd64(), rnd64(), rnd_nb(), 1'b0);
        if (shape < 8) return;
        add_beat(OP_PT, rnd64(), rnd64(), rnd64(), rnd_nb(), 1'b1);
    endtask

    task automatic load_key(input logic idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == REG_KEY_HIGH) key_hi = val;
        else key_lo = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        while (pending_beats.size() != 0 || i_valid || expected_beats.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int ph, target;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        load_key(REG_KEY_HIGH, '0);
        load_key(REG_KEY_LOW, '0);

        // not started, unknown op
        add_beat(OP_PT, '0, '0, '1, 4'd8, 1'b1);
        add_beat(OP_AD, '1, '1, '1, 4'd8, 1'b1);
        add_beat(2'd3, '1, '1, '1, 4'd15, 1'b1);
        // empty associated data, empty final plaintext
        add_beat(OP_START, '0, '0, '0, 4'd0, 1'b0);
        add_beat(OP_AD, '0, '0, '1, 4'd0, 1'b1);
        add_beat(OP_PT, '0, '0, '1, 4'd0, 1'b1);
        // full final blocks, non-final byte count ignored
        add_beat(OP_START, '1, '1, '1, 4'd15, 1'b1);
        add_beat(OP_AD, '1, '1, '1, 4'd15, 1'b0);
        add_beat(OP_AD, '0, '0, '1, 4'd8, 1'b1);
        add_beat(OP_PT, '1, '1, '0, 4'd3, 1'b0);
        add_beat(OP_PT, '0, '0, '1, 4'd8, 1'b1);
        // unterminated associated data
        add_beat(OP_START, rnd64(), rnd64(), '0, 4'd0, 1'b0);
        add_beat(OP_AD, '0, '0, rnd64(), 4'd2, 1'b0);
        add_beat(OP_PT, '0, '0, '1, 4'd3, 1'b1);
        // oversize count, late associated data, unknown op mid message
        add_beat(OP_START, rnd64(), rnd64(), '0, 4'd0, 1'b0);
        add_beat(OP_AD, '0, '0, rnd64(), 4'd12, 1'b1);
        add_beat(OP_AD, '0, '0, '1, 4'd4, 1'b1);
        add_beat(2'd3, '0, '0, '1, 4'd1, 1'b1);
        add_beat(OP_PT, '0, '0, '1, 4'd7, 1'b1);
        // restart
        add_beat(OP_START, rnd64(), rnd64(), '0, 4'd0, 1'b0);
        add_beat(OP_AD, '0, '0, rnd64(), 4'd8, 1'b0);
        add_beat(OP_START, rnd64(), rnd64(), '0, 4'd0, 1'b0);
        add_beat(OP_AD, '0, '0, '1, 4'd5, 1'b1);
        add_beat(OP_PT, '0, '0, '1, 4'd1, 1'b1);
        settle();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin load_key(REG_KEY_HIGH, '1); load_key(REG_KEY_LOW, '1); end
                1: begin load_key(REG_KEY_HIGH, '0); load_key(REG_KEY_LOW, '1); end
                4: begin load_key(REG_KEY_HIGH, '1); load_key(REG_KEY_LOW, '0); end
                default: begin
                    load_key(REG_KEY_HIGH, {$urandom, $urandom});
                    load_key(REG_KEY_LOW, {$urandom, $urandom});
                end
            endcase
            target = beats_queued + PHASE_BEATS;
            while (beats_queued < target) begin
                if ($urandom_range(0, 99) < 6)
                    add_beat(2'($urandom_range(1, 3)), rnd64(), rnd64(), rnd64(),
                             4'($urandom), 1'($urandom));
                add_message();
            end
            settle();
        end

        if (errors == 0) begin
            $display("ascon128_aead_encrypt_unit: match");
        end else begin
            $display("ascon128_aead_encrypt_unit: mismatch");
        end
        $finish;
    end

endmodule
